>>> design/assert_macros.svh
// Assertion helpers used by the checker file.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define SPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is active.
`define SPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

>>> design/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Types and constants shared by the serial packet deframer modules.
// ----------------------------------------------------------------------------
package spd_pkg;

  // Width of a payload store pointer; covers stores of up to 64 bytes.
  localparam int unsigned PTR_W = 6;

  // Hard cap on the number of results one frame may produce.
  localparam int unsigned RESULT_LIMIT = 32;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_START_MARKER = 2'd0,
    CFG_MAX_LENGTH   = 2'd1,
    CFG_CHECK_MODE   = 2'd2,
    CFG_FIXED_CHECK  = 2'd3
  } cfg_index_e;

  // Reset values of the configuration registers.
  localparam logic [7:0] START_MARKER_RST = 8'hAA;
  localparam logic [5:0] MAX_LENGTH_RST   = 6'd32;
  localparam logic       CHECK_MODE_RST   = 1'b1;
  localparam logic [7:0] FIXED_CHECK_RST  = 8'hFF;

  // Check modes.
  localparam logic MODE_SUM   = 1'b0;
  localparam logic MODE_FIXED = 1'b1;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_ID    = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4,
    PH_EMIT  = 3'd5
  } phase_e;

  // Access request from the controller to the payload store.
  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } mem_req_t;

endpackage

>>> design/spd_in_if.sv
// ----------------------------------------------------------------------------
// spd_in_if
// Received byte channel: valid/ready handshake with one byte of payload.
// ----------------------------------------------------------------------------
interface spd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> design/spd_out_if.sv
// ----------------------------------------------------------------------------
// spd_out_if
// Frame result channel: valid/ready handshake with one result per transaction.
// ----------------------------------------------------------------------------
interface spd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_id;
  logic [5:0] frame_length;
  logic       has_byte;
  logic [4:0] byte_index;
  logic [7:0] payload_byte;
  logic       last;

  modport source (
    output valid, output frame_id, output frame_length, output has_byte,
    output byte_index, output payload_byte, output last, input ready
  );
  modport sink (
    input valid, input frame_id, input frame_length, input has_byte,
    input byte_index, input payload_byte, input last, output ready
  );
endinterface

>>> design/spd_store.sv
// ----------------------------------------------------------------------------
// spd_store
// Payload byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module spd_store #(
  parameter int unsigned DEPTH = 32
) (
  input  logic              clk_i,
  input  spd_pkg::mem_req_t req_i,
  output logic [7:0]        rdata_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/spd_ctrl.sv
// ----------------------------------------------------------------------------
// spd_ctrl
// Frame parser, configuration registers and readout sequencer.
// ----------------------------------------------------------------------------
module spd_ctrl #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  spd_in_if.sink            in_i,
  spd_out_if.source         out_o,
  output spd_pkg::mem_req_t mem_req_o,
  input  logic [7:0]        mem_rdata_i
);

  localparam int unsigned CAP =
    (MAX_PAYLOAD < spd_pkg::RESULT_LIMIT) ? MAX_PAYLOAD : spd_pkg::RESULT_LIMIT;
  localparam logic [5:0] CAP_LEN = 6'(CAP);

  spd_pkg::phase_e phase_q, phase_d;
  logic [7:0] start_marker_q, fixed_check_q;
  logic [5:0] max_length_q;
  logic       check_mode_q;
  logic [7:0] id_q, id_d;
  logic [5:0] len_q, len_d;
  logic [5:0] fill_q, fill_d;
  logic [7:0] sum_q, sum_d;
  logic [5:0] rd_idx_q, rd_idx_d;
  logic       pend_q, pend_d;
  logic       out_valid_q, out_valid_d;

  logic       load;
  logic       ld_has_byte, ld_last;
  logic [4:0] ld_index;
  logic [7:0] ld_byte;
  logic [5:0] ld_length;

  logic [7:0] out_id_q, out_byte_q;
  logic [5:0] out_length_q;
  logic [4:0] out_index_q;
  logic       out_has_byte_q, out_last_q;

  logic       in_fire, slot_free;
  logic [7:0] ch, expect_byte;
  logic [5:0] limit, fill_inc;

  assign ch        = in_i.rx_byte;
  assign in_fire   = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;
  assign limit     = (max_length_q < CAP_LEN) ? max_length_q : CAP_LEN;
  assign fill_inc  = fill_q + 6'd1;
  assign expect_byte = (check_mode_q == spd_pkg::MODE_FIXED) ? fixed_check_q : sum_q;

  // Handshake and store access.
  always_comb begin
    in_i.ready      = (phase_q != spd_pkg::PH_EMIT);
    mem_req_o.we    = in_fire && (phase_q == spd_pkg::PH_DATA);
    mem_req_o.waddr = fill_q;
    mem_req_o.wdata = ch;
    mem_req_o.re    = (phase_q == spd_pkg::PH_EMIT) && (len_q != 6'd0) &&
                      !pend_q && slot_free;
    mem_req_o.raddr = rd_idx_q;
  end

  // Next state of the parser and the readout sequencer.
  always_comb begin
    phase_d     = phase_q;
    id_d        = id_q;
    len_d       = len_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = pend_q;
    load        = 1'b0;
    ld_has_byte = 1'b0;
    ld_last     = 1'b0;
    ld_index    = 5'd0;
    ld_byte     = 8'd0;
    ld_length   = 6'd0;
    case (phase_q)
      spd_pkg::PH_HUNT: begin
        if (in_fire) begin
          sum_d = ch;
          if (ch == start_marker_q) begin
            phase_d = spd_pkg::PH_ID;
          end
        end
      end
      spd_pkg::PH_ID: begin
        if (in_fire) begin
          id_d    = ch;
          sum_d   = sum_q + ch;
          phase_d = spd_pkg::PH_LEN;
        end
      end
      spd_pkg::PH_LEN: begin
        if (in_fire) begin
          if (ch <= {2'b00, limit}) begin
            len_d   = ch[5:0];
            fill_d  = 6'd0;
            sum_d   = sum_q + ch;
            phase_d = (ch != 8'd0) ? spd_pkg::PH_DATA : spd_pkg::PH_CHECK;
          end else begin
            phase_d = spd_pkg::PH_HUNT;
          end
        end
      end
      spd_pkg::PH_DATA: begin
        if (in_fire) begin
          fill_d = fill_inc;
          sum_d  = sum_q + ch;
          if (fill_inc == len_q) begin
            phase_d = spd_pkg::PH_CHECK;
          end
        end
      end
      spd_pkg::PH_CHECK: begin
        if (in_fire) begin
          rd_idx_d = 6'd0;
          pend_d   = 1'b0;
          phase_d  = (ch == expect_byte) ? spd_pkg::PH_EMIT : spd_pkg::PH_HUNT;
        end
      end
      spd_pkg::PH_EMIT: begin
        if (len_q == 6'd0) begin
          // Empty frame: a single result without a byte.
          if (slot_free) begin
            load    = 1'b1;
            ld_last = 1'b1;
            phase_d = spd_pkg::PH_HUNT;
          end
        end else if (pend_q) begin
          // Read data has arrived; the output slot is known to be free.
          load        = 1'b1;
          ld_has_byte = 1'b1;
          ld_length   = len_q;
          ld_index    = 5'(rd_idx_q - 6'd1);
          ld_byte     = mem_rdata_i;
          ld_last     = (rd_idx_q == len_q);
          pend_d      = 1'b0;
          if (rd_idx_q == len_q) begin
            phase_d = spd_pkg::PH_HUNT;
          end
        end else if (slot_free) begin
          rd_idx_d = rd_idx_q + 6'd1;
          pend_d   = 1'b1;
        end
      end
      default: begin
        phase_d = spd_pkg::PH_HUNT;
      end
    endcase
    out_valid_d = (out_valid_q && !out_o.ready) || load;
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= spd_pkg::PH_HUNT;
      id_q        <= 8'd0;
      len_q       <= 6'd0;
      fill_q      <= 6'd0;
      sum_q       <= 8'd0;
      rd_idx_q    <= 6'd0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      id_q        <= id_d;
      len_q       <= len_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      rd_idx_q    <= rd_idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= spd_pkg::START_MARKER_RST;
      max_length_q   <= spd_pkg::MAX_LENGTH_RST;
      check_mode_q   <= spd_pkg::CHECK_MODE_RST;
      fixed_check_q  <= spd_pkg::FIXED_CHECK_RST;
    end else if (cfg_we_i) begin
      case (spd_pkg::cfg_index_e'(cfg_index_i))
        spd_pkg::CFG_START_MARKER: start_marker_q <= cfg_data_i;
        spd_pkg::CFG_MAX_LENGTH:   max_length_q   <= cfg_data_i[5:0];
        spd_pkg::CFG_CHECK_MODE:   check_mode_q   <= cfg_data_i[0];
        spd_pkg::CFG_FIXED_CHECK:  fixed_check_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_id_q       <= id_q;
      out_length_q   <= ld_length;
      out_has_byte_q <= ld_has_byte;
      out_index_q    <= ld_index;
      out_byte_q     <= ld_byte;
      out_last_q     <= ld_last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.frame_id     = out_id_q;
  assign out_o.frame_length = out_length_q;
  assign out_o.has_byte     = out_has_byte_q;
  assign out_o.byte_index   = out_index_q;
  assign out_o.payload_byte = out_byte_q;
  assign out_o.last         = out_last_q;

endmodule

>>> design/serial_packet_deframer.sv
// ----------------------------------------------------------------------------
// serial_packet_deframer
// Parses start, id, length, payload and check bytes and delivers good frames.
// ----------------------------------------------------------------------------
// While a frame is being parsed the block takes one byte per cycle. Once a
// frame passes its check byte, the input is held off while the frame is read
// out of the payload store: each payload byte is read through the store's
// registered read port and then loaded into the output register, and the next
// byte is read only while the output slot is free. The input opens again as
// soon as the last result sits in the output register. The store needs no
// clearing after reset; only bytes written in the current frame are read out.
module serial_packet_deframer #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  spd_in_if.sink     in_i,
  spd_out_if.source  out_o
);

  spd_pkg::mem_req_t mem_req;
  logic [7:0]        mem_rdata;

  // Parser and readout control.
  spd_ctrl #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // Payload byte store.
  spd_store #(
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

>>> design/spd_checker.sv
// ----------------------------------------------------------------------------
// spd_checker
// Port-level checks of the deframer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] frame_id_i,
  input logic [5:0] frame_length_i,
  input logic       has_byte_i,
  input logic [4:0] byte_index_i,
  input logic [7:0] payload_byte_i,
  input logic       last_i
);

  logic [5:0] index_next;
  assign index_next = 6'(byte_index_i) + 6'd1;

  // A pending result that is not taken holds its payload.
  `SPD_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(frame_id_i) && $stable(payload_byte_i) && $stable(byte_index_i) && $stable(last_i))

  // A frame still being read out keeps the input closed.
  `SPD_ASSERT_NOW(a_readout_blocks_input, out_valid_i && !last_i, !in_ready_i)

  // An empty-frame result is the only result of its frame and carries zeros.
  `SPD_ASSERT_NOW(a_empty_frame, out_valid_i && !has_byte_i, last_i && (frame_length_i == 6'd0) && (byte_index_i == 5'd0) && (payload_byte_i == 8'd0))

  // Byte results stay inside the frame and mark the final byte as last.
  `SPD_ASSERT_NOW(a_byte_position, out_valid_i && has_byte_i, (index_next <= frame_length_i) && (last_i == (index_next == frame_length_i)))

endmodule

bind serial_packet_deframer spd_checker u_spd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .frame_id_i     (out_o.frame_id),
  .frame_length_i (out_o.frame_length),
  .has_byte_i     (out_o.has_byte),
  .byte_index_i   (out_o.byte_index),
  .payload_byte_i (out_o.payload_byte),
  .last_i         (out_o.last)
);

>>> tb/sv/serial_packet_deframer_tb.sv
// ----------------------------------------------------------------------------
// serial_packet_deframer_tb
// Self-checking bench for the serial packet deframer. Frames are built from
// the current register values and sent byte by byte with random input gaps
// and output back-pressure. A parser model in the bench predicts the results
// of unpinned frames; every result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module serial_packet_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAYLOAD_CAP  = 32;
  localparam int PHASE_BYTES  = 28;
  localparam int DRAIN_CYCLES = 12;

  // One frame result as it leaves the block.
  typedef struct packed {
    logic [7:0] frame_id;
    logic [5:0] frame_length;
    logic       has_byte;
    logic [4:0] byte_index;
    logic [7:0] payload_byte;
    logic       last;
  } frame_result_t;

  // Per-byte note from the sender: a pinned byte carries a typed expectation.
  typedef struct {
    bit         pinned;
    int         pin_count;
    logic [7:0] pin_id;
  } byte_tag_t;

  typedef struct {
    logic [7:0] marker;
    logic [5:0] max_len;
    logic       mode;
    logic [7:0] fixed_val;
  } reg_setting_t;

  typedef enum int {FR_GOOD, FR_BAD_CHECK, FR_TOO_LONG} frame_kind_e;

  typedef struct {
    logic        mode;
    logic [5:0]  max_len;
    logic [7:0]  frame_id;
    logic [7:0]  len_byte;
    logic [7:0]  fill;
    frame_kind_e kind;
    bit          pinned;
    int          pin_count;
  } directed_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  spd_in_if  in_if ();
  spd_out_if out_if ();

  serial_packet_deframer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Register copy used by the parser model and the frame builder.
  logic [7:0] cfg_marker;
  logic [5:0] cfg_maxlen;
  logic       cfg_mode;
  logic [7:0] cfg_fixed;

  // Parser model state.
  spd_pkg::phase_e prs_phase;
  logic [7:0] prs_id;
  logic [5:0] prs_len;
  logic [5:0] prs_fill;
  logic [7:0] prs_sum;
  logic [7:0] prs_store [PAYLOAD_CAP];

  frame_result_t fresh_results [$];
  frame_result_t pending_results [$];
  byte_tag_t     byte_tags [$];

  int errors;
  int queued_bytes;
  int rx_count;
  int results_seen;
  int frames_seen;
  int settings_used;
  int gap_odds;
  bit calm;

  frame_result_t got;
  frame_result_t want;
  byte_tag_t     tag_now;

  // Directed frames; pinned rows carry their outcome typed in.
  directed_row_t dir_rows [7] = '{
    '{spd_pkg::MODE_FIXED, 6'd32, 8'h00, 8'd0,   8'h00, FR_GOOD,      1'b1, 1},
    '{spd_pkg::MODE_FIXED, 6'd32, 8'hFF, 8'd0,   8'h00, FR_BAD_CHECK, 1'b1, 0},
    '{spd_pkg::MODE_FIXED, 6'd32, 8'h55, 8'd33,  8'h00, FR_TOO_LONG,  1'b1, 0},
    '{spd_pkg::MODE_FIXED, 6'd32, 8'h81, 8'd1,   8'hFF, FR_GOOD,      1'b0, 0},
    '{spd_pkg::MODE_FIXED, 6'd32, 8'h7E, 8'd255, 8'h00, FR_TOO_LONG,  1'b1, 0},
    '{spd_pkg::MODE_SUM,   6'd2,  8'hC3, 8'd2,   8'h00, FR_GOOD,      1'b0, 0},
    '{spd_pkg::MODE_SUM,   6'd2,  8'hFF, 8'd0,   8'h00, FR_GOOD,      1'b1, 1}
  };

  // Register settings of the random part; the last one runs without idling.
  reg_setting_t reg_plan [6] = '{
    '{8'h00, 6'd32, spd_pkg::MODE_SUM,   8'h00},
    '{8'hFF, 6'd0,  spd_pkg::MODE_FIXED, 8'h00},
    '{8'h5A, 6'd63, spd_pkg::MODE_SUM,   8'hFF},
    '{8'h3C, 6'd7,  spd_pkg::MODE_FIXED, 8'h81},
    '{8'hC3, 6'd40, spd_pkg::MODE_SUM,   8'h7E},
    '{8'hAA, 6'd32, spd_pkg::MODE_FIXED, 8'hFF}
  };

  // Largest payload length the parser accepts under the current registers.
  function automatic int length_cap();
    int lim;
    lim = int'(cfg_maxlen);
    if (lim > PAYLOAD_CAP) lim = PAYLOAD_CAP;
    if (lim > int'(spd_pkg::RESULT_LIMIT)) lim = int'(spd_pkg::RESULT_LIMIT);
    return lim;
  endfunction

  // Advance the parser model by one byte; results go to fresh_results.
  function automatic void deframe_step(input logic [7:0] ch);
    logic [7:0] check_val;
    case (prs_phase)
      spd_pkg::PH_HUNT: begin
        // The running sum is seeded with every byte seen while hunting.
        if (ch == cfg_marker) prs_phase = spd_pkg::PH_ID;
        prs_sum = ch;
      end
      spd_pkg::PH_ID: begin
        prs_id    = ch;
        prs_sum   = prs_sum + ch;
        prs_phase = spd_pkg::PH_LEN;
      end
      spd_pkg::PH_LEN: begin
        if (int'(ch) <= length_cap()) begin
          prs_len   = ch[5:0];
          prs_fill  = 6'd0;
          prs_sum   = prs_sum + ch;
          prs_phase = (ch != 8'd0) ? spd_pkg::PH_DATA : spd_pkg::PH_CHECK;
        end else begin
          prs_phase = spd_pkg::PH_HUNT;
        end
      end
      spd_pkg::PH_DATA: begin
        if (prs_fill < PAYLOAD_CAP) prs_store[prs_fill] = ch;
        prs_fill = prs_fill + 6'd1;
        prs_sum  = prs_sum + ch;
        if (prs_fill == prs_len) prs_phase = spd_pkg::PH_CHECK;
      end
      spd_pkg::PH_CHECK: begin
        check_val = (cfg_mode == spd_pkg::MODE_FIXED) ? cfg_fixed : prs_sum;
        prs_phase = spd_pkg::PH_HUNT;
        if (check_val == ch) begin
          if (prs_len == 6'd0) begin
            // An empty frame reads out as one marker result.
            fresh_results.push_back('{prs_id, 6'd0, 1'b0, 5'd0, 8'd0, 1'b1});
          end else begin
            for (int k = 0; k < prs_len && k < PAYLOAD_CAP &&
                 k < int'(spd_pkg::RESULT_LIMIT); k++) begin
              fresh_results.push_back('{prs_id, prs_len, 1'b1, k[4:0], prs_store[k],
                                        (k + 1 == prs_len)});
            end
          end
        end
      end
      default: prs_phase = spd_pkg::PH_HUNT;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_val,
                                      input logic [7:0] act_val);
    if (exp_val !== act_val) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name,
               exp_val, act_val);
    end
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver back-pressure: random stall bursts, with ready held high while calm.
  initial begin
    int hold;
    hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (calm) begin
        out_if.ready <= 1'b1;
      end else if (hold > 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else if ($urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        hold = $urandom_range(0, 5);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each input transaction, check each output transaction.
  always @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      rx_count++;
      if (byte_tags.size() == 0) begin
        errors++;
        $display("%0t ns: byte accepted that was never offered", $time);
      end else begin
        tag_now = byte_tags.pop_front();
        fresh_results.delete();
        deframe_step(in_if.rx_byte);
        if (tag_now.pinned) begin
          if (tag_now.pin_count == 1)
            pending_results.push_back('{tag_now.pin_id, 6'd0, 1'b0, 5'd0, 8'd0, 1'b1});
        end else begin
          foreach (fresh_results[i]) pending_results.push_back(fresh_results[i]);
        end
      end
    end
    if (out_if.valid && out_if.ready) begin
      got = '{out_if.frame_id, out_if.frame_length, out_if.has_byte,
              out_if.byte_index, out_if.payload_byte, out_if.last};
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual %p", $time, got);
      end else begin
        want = pending_results.pop_front();
        check_field("frame_id", want.frame_id, got.frame_id);
        check_field("frame_length", 8'(want.frame_length), 8'(got.frame_length));
        check_field("has_byte", 8'(want.has_byte), 8'(got.has_byte));
        check_field("byte_index", 8'(want.byte_index), 8'(got.byte_index));
        check_field("payload_byte", want.payload_byte, got.payload_byte);
        check_field("last", 8'(want.last), 8'(got.last));
        if (got.last) frames_seen++;
      end
    end
  end

  // Offer one byte, with an optional gap first, and wait for its transaction.
  task automatic push_rx_byte(input logic [7:0] b, input byte_tag_t tag);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    byte_tags.push_back(tag);
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    queued_bytes++;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Build a frame against the current registers and send it.
  task automatic send_frame(input logic [7:0] fid, input logic [7:0] len_byte,
                            input frame_kind_e kind, input logic [7:0] fill,
                            input bit rand_body, input bit pinned, input int pin_count);
    logic [7:0] frame_bytes [$];
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] chk;
    byte_tag_t  tag;
    frame_bytes.push_back(cfg_marker);
    frame_bytes.push_back(fid);
    frame_bytes.push_back(len_byte);
    sum = cfg_marker + fid + len_byte;
    b = fill;
    if (kind != FR_TOO_LONG) begin
      for (int k = 0; k < len_byte; k++) begin
        if (rand_body) b = 8'($urandom_range(0, 255));
        frame_bytes.push_back(b);
        sum = sum + b;
        if (!rand_body) b = b + 8'h11;
      end
      chk = (cfg_mode == spd_pkg::MODE_FIXED) ? cfg_fixed : sum;
      if (kind == FR_BAD_CHECK) chk = chk ^ (8'h01 << $urandom_range(0, 7));
      frame_bytes.push_back(chk);
    end
    foreach (frame_bytes[i]) begin
      tag = '{pinned && (i == frame_bytes.size() - 1), pin_count, fid};
      push_rx_byte(frame_bytes[i], tag);
    end
  endtask

  // Wait until every predicted result has arrived and the block is quiet.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (byte_tags.size() != 0 || pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input spd_pkg::cfg_index_e idx, input logic [7:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input reg_setting_t s);
    write_reg(spd_pkg::CFG_START_MARKER, s.marker);
    write_reg(spd_pkg::CFG_MAX_LENGTH, {2'b00, s.max_len});
    write_reg(spd_pkg::CFG_CHECK_MODE, {7'd0, s.mode});
    write_reg(spd_pkg::CFG_FIXED_CHECK, s.fixed_val);
    cfg_we_i   <= 1'b0;
    cfg_marker = s.marker;
    cfg_maxlen = s.max_len;
    cfg_mode   = s.mode;
    cfg_fixed  = s.fixed_val;
    settings_used++;
  endtask

  // Run limit.
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Stimulus.
  initial begin
    int         cap;
    int         pick;
    int         len;
    int         phase_start;
    logic [7:0] fid;
    byte_tag_t  noise_tag;

    errors        = 0;
    queued_bytes  = 0;
    rx_count      = 0;
    results_seen  = 0;
    frames_seen   = 0;
    settings_used = 0;
    gap_odds      = 4;
    calm          = 1'b0;
    noise_tag     = '{1'b0, 0, 8'h00};

    cfg_marker = spd_pkg::START_MARKER_RST;
    cfg_maxlen = spd_pkg::MAX_LENGTH_RST;
    cfg_mode   = spd_pkg::CHECK_MODE_RST;
    cfg_fixed  = spd_pkg::FIXED_CHECK_RST;
    prs_phase  = spd_pkg::PH_HUNT;
    prs_id     = 8'd0;
    prs_len    = 6'd0;
    prs_fill   = 6'd0;
    prs_sum    = 8'd0;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= spd_pkg::CFG_START_MARKER;
    cfg_data_i    <= 8'd0;
    in_if.valid   <= 1'b0;
    in_if.rx_byte <= 8'd0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames, starting from the reset register values.
    foreach (dir_rows[r]) begin
      if (dir_rows[r].mode != cfg_mode || dir_rows[r].max_len != cfg_maxlen) begin
        drain_results();
        program_regs('{cfg_marker, dir_rows[r].max_len, dir_rows[r].mode, cfg_fixed});
      end
      send_frame(dir_rows[r].frame_id, dir_rows[r].len_byte, dir_rows[r].kind,
                 dir_rows[r].fill, 1'b0, dir_rows[r].pinned, dir_rows[r].pin_count);
    end

    // Random frames, one register setting per phase.
    foreach (reg_plan[s]) begin
      drain_results();
      calm = (s == $size(reg_plan) - 1);
      program_regs(reg_plan[s]);
      phase_start = queued_bytes;
      while (queued_bytes - phase_start < PHASE_BYTES) begin
        cap      = length_cap();
        gap_odds = calm ? 0 : (($urandom_range(0, 2) == 0) ? 0 : 4);
        pick     = $urandom_range(0, 9);
        fid      = 8'($urandom_range(0, 255));
        if (cap == 0) len = 0;
        else if ($urandom_range(0, 7) == 0) len = cap;
        else len = $urandom_range(0, (cap < 6) ? cap : 6);
        if (pick <= 6) begin
          send_frame(fid, len[7:0], FR_GOOD, 8'h00, 1'b1, 1'b0, 0);
        end else if (pick == 7) begin
          send_frame(fid, len[7:0], FR_BAD_CHECK, 8'h00, 1'b1, 1'b0, 0);
        end else if (pick == 8) begin
          len = $urandom_range(cap + 1, 255);
          send_frame(fid, len[7:0], FR_TOO_LONG, 8'h00, 1'b1, 1'b0, 0);
        end else begin
          // Line noise between frames.
          repeat ($urandom_range(1, 3)) push_rx_byte(8'($urandom_range(0, 255)), noise_tag);
        end
      end
    end

    drain_results();
    $display("Sent %0d bytes under %0d register settings, with random gaps and stalls.",
             rx_count, settings_used);
    $display("Checked %0d results from %0d delivered frames.", results_seen, frames_seen);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
